>>> hdl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg: shared types and constants for the ordered array list
// Operation codes, item structs for both channels and the cell command.
// ----------------------------------------------------------------------------
package oal_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_LOCATE = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
   } oal_req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         list_length;
   } oal_rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic [1:0]               kind;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
      logic                     write_en;
   } oal_cmd_type;

endpackage

>>> hdl/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell: one list slot
// Holds one entry, shifts with its neighbors on insert/delete, and feeds
// the read-out and first-match chains.
// ----------------------------------------------------------------------------
module oal_cell
   import oal_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  oal_cmd_type                          cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]        count,
   input  logic signed [DATA_W-1:0]             left_value,
   input  logic signed [DATA_W-1:0]             right_value,
   output logic signed [DATA_W-1:0]             entry_value,
   input  logic signed [DATA_W-1:0]             rd_in,
   output logic signed [DATA_W-1:0]             rd_out,
   input  logic [$clog2(CAPACITY+1)-1:0]        found_in,
   output logic [$clog2(CAPACITY+1)-1:0]        found_out
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic [CMPW-1:0]          slot_w, pos_w, cnt_w;
   logic                     hit, match;

   assign slot_w = CMPW'(INDEX + 1);
   assign pos_w  = CMPW'(cmd.position);
   assign cnt_w  = CMPW'(count);

   assign hit   = (slot_w == pos_w);
   assign match = (entry_ff == cmd.item_value) && (slot_w <= cnt_w);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.write_en) begin
         case (cmd.kind)
            OP_INSERT: begin
               if (hit)
                  entry_in = cmd.item_value;
               else if (slot_w > pos_w)
                  entry_in = left_value;
            end
            OP_DELETE: begin
               if (slot_w >= pos_w)
                  entry_in = right_value;
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         entry_ff <= '0;
      else
         entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign rd_out      = rd_in | (hit ? entry_ff : '0);
   // earliest match wins: pass on what came from below
   assign found_out   = (found_in != '0) ? found_in : (match ? CW'(INDEX + 1) : '0);

endmodule

>>> hdl/ordered_array_list.sv
// ----------------------------------------------------------------------------
// ordered_array_list: fixed-capacity list with positional insert/delete
// A row of slot cells that shift in parallel; one result item per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one request item:
//   kind (insert, delete, get, locate), a 1-based position and a value.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one item per
//   request: ok, read_value, found_position and list_length after the op.
//   Result: registered; it shows in the cycle after acceptance.
//   Throughput: one item per cycle unless a result stalls. Every cell shifts,
//   compares and drives the read-out chain in the same cycle, so the whole
//   list updates at once; only the output register can hold the input back.
//   Stall: while a result waits with rsp_ready low, req_ready is low; when
//   the result is taken, a new request can be accepted in that same cycle.
//   Reset (synchronous, active high): all entries clear to zero, the length
//   goes to zero and any pending result is dropped.
//   Locate searches only the first list_length entries; the lowest matching
//   position is reported.
// ----------------------------------------------------------------------------
module ordered_array_list
   import oal_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  oal_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output oal_rsp_type rsp_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   oal_rsp_type     rsp_data_ff, rsp_data_in;

   logic            accept;
   logic [CMPW-1:0] pos_w, cnt_w;
   logic            pos_nz, in_range, ins_ok;
   oal_cmd_type     cmd;

   // cell chains
   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   logic signed [DATA_W-1:0] rd_chain [CAPACITY+1];
   logic [CW-1:0]            found_chain [CAPACITY+1];

   // output register frees up when its item is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // bounds checks, done wide enough for any capacity
   assign pos_w    = CMPW'(req_data.position);
   assign cnt_w    = CMPW'(count_ff);
   assign pos_nz   = (pos_w != '0);
   assign in_range = pos_nz && (pos_w <= cnt_w);
   assign ins_ok   = pos_nz && (pos_w <= cnt_w + CMPW'(1)) && (cnt_w < CMPW'(CAPACITY));

   always_comb begin
      cmd.kind       = req_data.kind;
      cmd.position   = req_data.position;
      cmd.item_value = req_data.item_value;
      cmd.write_en   = 1'b0;
      case (req_data.kind)
         OP_INSERT: cmd.write_en = accept && ins_ok;
         OP_DELETE: cmd.write_en = accept && in_range;
         default:   cmd.write_en = 1'b0;
      endcase
   end

   assign rd_chain[0]    = '0;
   assign found_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v, right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;          // never used: position starts at 1
      end else begin : g_mid
         assign left_v = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = entry_w[i]; // top slot keeps its value on delete
      end else begin : g_body
         assign right_v = entry_w[i+1];
      end

      oal_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .count       (count_ff),
         .left_value  (left_v),
         .right_value (right_v),
         .entry_value (entry_w[i]),
         .rd_in       (rd_chain[i]),
         .rd_out      (rd_chain[i+1]),
         .found_in    (found_chain[i]),
         .found_out   (found_chain[i+1])
      );
   end

   // result and next length
   always_comb begin
      count_in                   = count_ff;
      rsp_data_in.ok             = 1'b0;
      rsp_data_in.read_value     = '0;
      rsp_data_in.found_position = '0;
      case (req_data.kind)
         OP_INSERT: begin
            rsp_data_in.ok = ins_ok;
            if (ins_ok)
               count_in = count_ff + CW'(1);
         end
         OP_DELETE: begin
            rsp_data_in.ok = in_range;
            if (in_range) begin
               rsp_data_in.read_value = rd_chain[CAPACITY];
               count_in               = count_ff - CW'(1);
            end
         end
         OP_GET: begin
            rsp_data_in.ok = in_range;
            if (in_range)
               rsp_data_in.read_value = rd_chain[CAPACITY];
         end
         OP_LOCATE: begin
            rsp_data_in.ok             = (found_chain[CAPACITY] != '0);
            rsp_data_in.found_position = POS_W'(found_chain[CAPACITY]);
         end
         default: rsp_data_in.ok = 1'b0;
      endcase
      rsp_data_in.list_length = POS_W'(count_in);
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept)
            count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/oal_checker.sv
// ----------------------------------------------------------------------------
// oal_checker: port-level checks for the ordered array list
// Watches both channels; bound to the top level.
// ----------------------------------------------------------------------------
module oal_checker
   import oal_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input oal_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every accepted request yields a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no result");

   // a failed op reports no data
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.read_value == '0 &&
                                    rsp_data.found_position == '0)
      else $error("failed op carries data");

   // length never exceeds capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 31) || (int'(rsp_data.list_length) <= CAPACITY))
      else $error("list length above capacity");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ordered_array_list oal_checker #(.CAPACITY(CAPACITY)) u_oal_checker (.*);

>>> verif/oal_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oal_list_checker: scoreboard for the ordered array list
// Watches both channels, keeps its own copy of the list, predicts each result
// item on request acceptance and compares accepted results in order.
// ----------------------------------------------------------------------------
module oal_list_checker
   import oal_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  oal_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  oal_rsp_type rsp_data,
   output int          mismatch_count,
   output int          results_pending,
   output int          results_checked
);

   logic signed [DATA_W-1:0] slots [CAPACITY];
   int                       list_len;
   oal_rsp_type              pending_results [$];
   oal_rsp_type              want;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      results_checked = 0;
   end

   // apply one request to the shadow list, return the result it produces
   function automatic oal_rsp_type apply_list_op(input oal_req_type rq);
      oal_rsp_type rs;
      int          p;
      int          j;
      int          hit;
      rs  = '0;
      p   = int'(rq.position);
      hit = 0;
      case (rq.kind)
         OP_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
               for (j = list_len; j >= p; j--)
                  slots[j] = slots[j-1];
               slots[p-1] = rq.item_value;
               list_len++;
               rs.ok = 1'b1;
            end
         end
         OP_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               rs.read_value = slots[p-1];
               for (j = p; j < list_len; j++)
                  slots[j-1] = slots[j];
               list_len--;
               rs.ok = 1'b1;
            end
         end
         OP_GET: begin
            if (p >= 1 && p <= list_len) begin
               rs.read_value = slots[p-1];
               rs.ok         = 1'b1;
            end
         end
         default: begin
            // first match only, within the live part of the list
            for (j = 0; j < list_len; j++) begin
               if (hit == 0 && slots[j] == rq.item_value)
                  hit = j + 1;
            end
            rs.ok             = (hit != 0);
            rs.found_position = hit[POS_W-1:0];
         end
      endcase
      rs.list_length = list_len[POS_W-1:0];
      return rs;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++)
            slots[i] = '0;
         list_len = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: stray result, expected none, got %0b/%0d/%0d/%0d",
                        $time, rsp_data.ok, $signed(rsp_data.read_value),
                        rsp_data.found_position, rsp_data.list_length);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_data.ok !== want.ok) begin
                  $display("%0t ns: ok mismatch, expected %0b, got %0b",
                           $time, want.ok, rsp_data.ok);
                  mismatch_count++;
               end
               if (rsp_data.read_value !== want.read_value) begin
                  $display("%0t ns: read_value mismatch, expected %0d, got %0d",
                           $time, $signed(want.read_value), $signed(rsp_data.read_value));
                  mismatch_count++;
               end
               if (rsp_data.found_position !== want.found_position) begin
                  $display("%0t ns: found_position mismatch, expected %0d, got %0d",
                           $time, want.found_position, rsp_data.found_position);
                  mismatch_count++;
               end
               if (rsp_data.list_length !== want.list_length) begin
                  $display("%0t ns: list_length mismatch, expected %0d, got %0d",
                           $time, want.list_length, rsp_data.list_length);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(apply_list_op(req_data));
      end
      results_pending = pending_results.size();
   end

endmodule

>>> verif/tb_ordered_array_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list: regression for the ordered array list
// Directed corner items, then phases of random insert/delete/get/locate
// traffic with random idling on both channels; a checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb_ordered_array_list;
   import oal_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 1200;
   localparam int LONG_HOLD    = 250;        // receiver hold-off, cycles
   localparam int TIMEOUT_NS   = 4_000_000;  // far above the slowest run

   typedef enum {PH_MIX, PH_GROW, PH_SHRINK, PH_PROBE, PH_FILL} phase_mode_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   oal_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   oal_rsp_type rsp_data;

   int  mismatch_count;
   int  results_pending;
   int  results_checked;

   // shared between the sender and the receiver process
   bit  quiet            = 1'b0;  // no random idling on either side while set
   bit  hold_off_request = 1'b0;  // sender asks the receiver for a long stall

   int  items_sent = 0;
   int  kind_tally [4];
   int  drain_count = 0;

   ordered_array_list #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   oal_list_checker #(
      .CAPACITY (CAPACITY)
   ) list_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic oal_req_type make_item(input logic [1:0] k, input int p,
                                             input logic [DATA_W-1:0] v);
      oal_req_type it;
      it.kind       = k;
      it.position   = p[POS_W-1:0];
      it.item_value = v;
      return it;
   endfunction

   // values from a small pool so locate hits often; the rest fully random
   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0)
         return $urandom;
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h0000_0001;
         5:       return 32'h0000_FFFF;
         6:       return 32'hA5A5_5A5A;
         default: return 32'd42;
      endcase
   endfunction

   function automatic oal_req_type random_item(input phase_mode_type mode);
      int         r;
      int         w_ins;
      int         w_del;
      int         w_get;
      int         p;
      logic [1:0] k;
      case (mode)
         PH_GROW:   begin w_ins = 70; w_del = 10; w_get = 10; end
         PH_SHRINK: begin w_ins = 10; w_del = 70; w_get = 10; end
         PH_PROBE:  begin w_ins = 15; w_del = 15; w_get = 35; end
         PH_FILL:   begin w_ins = 100; w_del = 0; w_get = 0; end
         default:   begin w_ins = 30; w_del = 25; w_get = 20; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_ins)
         k = OP_INSERT;
      else if (r < w_ins + w_del)
         k = OP_DELETE;
      else if (r < w_ins + w_del + w_get)
         k = OP_GET;
      else
         k = OP_LOCATE;
      // skew toward low positions so most requests land inside the list;
      // now and then any 5-bit position, bad ones included
      if (mode == PH_FILL)
         p = $urandom_range(1, 5);
      else if ($urandom_range(0, 99) < 85)
         p = $urandom_range(1, $urandom_range(1, CAPACITY + 1));
      else
         p = $urandom_range(0, 31);
      return make_item(k, p, pick_value());
   endfunction

   // offer one item and hold it until accepted, then maybe idle; valid is
   // left high when no gap follows so back-to-back items never toggle it
   task automatic send_item(input oal_req_type it);
      int gap;
      req_data  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
      kind_tally[it.kind]++;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering until every expected result item has come back; wait on
   // the clock first so the checker has booked the last accepted item
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_pending == 0);
      drain_count++;
   endtask

   // receiver: ready stretches broken by random stalls, plus one long
   // hold-off on request while the sender keeps pushing
   initial begin : sink_proc
      int on_len;
      int off_len;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         on_len = $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         off_len = quiet ? 0 : pick_gap();
         if (off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin : stim_proc
      int             random_sent;
      int             phase_no;
      int             phase_len;
      phase_mode_type mode;

      for (int i = 0; i < 4; i++)
         kind_tally[i] = 0;
      random_sent = 0;
      phase_no    = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty list, bad positions, extremes, stale slots ---
      send_item(make_item(OP_GET,    1, 32'd0));          // empty, bad
      send_item(make_item(OP_DELETE, 1, 32'd0));          // empty, bad
      send_item(make_item(OP_LOCATE, 0, 32'd0));          // reset zeros not searched
      send_item(make_item(OP_INSERT, 0, 32'd5));          // position zero
      send_item(make_item(OP_INSERT, 2, 32'd5));          // past length+1
      send_item(make_item(OP_INSERT, 1, 32'h7FFF_FFFF));
      send_item(make_item(OP_INSERT, 2, 32'h8000_0000));  // append
      send_item(make_item(OP_INSERT, 1, 32'h0000_0000));  // head, shifts up
      send_item(make_item(OP_INSERT, 4, 32'hFFFF_FFFF));
      send_item(make_item(OP_INSERT, 3, 32'h5555_AAAA));  // middle
      send_item(make_item(OP_GET,    1, 32'd0));
      send_item(make_item(OP_GET,    5, 32'd0));          // last entry
      send_item(make_item(OP_GET,    6, 32'd0));          // one past end
      send_item(make_item(OP_GET,   31, 32'd0));
      send_item(make_item(OP_GET,    0, 32'd0));
      send_item(make_item(OP_LOCATE, 0, 32'h8000_0000));
      send_item(make_item(OP_LOCATE, 0, 32'h1234_5678));  // absent
      send_item(make_item(OP_LOCATE, 0, 32'hFFFF_FFFF));  // at the tail
      send_item(make_item(OP_DELETE, 31, 32'd0));
      send_item(make_item(OP_DELETE, 0, 32'd0));
      send_item(make_item(OP_DELETE, 5, 32'd0));          // tail
      send_item(make_item(OP_DELETE, 1, 32'd0));          // head, shifts down
      send_item(make_item(OP_LOCATE, 0, 32'hFFFF_FFFF));  // deleted tail value, now absent
      send_item(make_item(OP_INSERT, 4, 32'd7));          // at length+1
      drain_results();

      // --- random phases: fill to full first, then delete-heavy, then mixed ---
      while (random_sent < RANDOM_ITEMS) begin
         case (phase_no)
            0:       mode = PH_FILL;
            1:       mode = PH_SHRINK;
            default: mode = phase_mode_type'($urandom_range(0, 3));
         endcase
         phase_len = (phase_no < 2) ? 28 : $urandom_range(30, 120);
         quiet     = ($urandom_range(0, 3) == 0);
         // long receiver stall with the sender still offering items
         if (phase_no == 3) begin
            quiet            = 1'b1;
            hold_off_request = 1'b1;
         end
         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            send_item(random_item(mode));
            random_sent++;
         end
         if (phase_no == 2 || $urandom_range(0, 3) == 0)
            drain_results();
         phase_no++;
      end

      quiet = 1'b0;
      drain_results();
      // wait on the clock to catch stray result items
      repeat (4) @(posedge clock);

      $display("Run covered %0d items (insert %0d, delete %0d, get %0d, locate %0d),",
               items_sent, kind_tally[OP_INSERT], kind_tally[OP_DELETE],
               kind_tally[OP_GET], kind_tally[OP_LOCATE]);
      $display("%0d result items checked, %0d drain pauses, one long receiver stall.",
               results_checked, drain_count);
      if (mismatch_count == 0 && results_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
